// ===== src/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnle_pkg;

  // Label index width: enough for a label of up to 63 characters.
  localparam int unsigned IdxW = 6;

  localparam logic [7:0] DotChar = 8'h2E;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_name;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_length;
    logic       label_overflow;
    logic       last_of_run;
  } out_word_t;

  // Flush command from the front part to the back part.
  typedef struct packed {
    logic            bank;
    logic [IdxW-1:0] count;
    logic            ovf;
  } flush_cmd_t;

  // Bank release from the back part once a label has been read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// ===== src/dnle_ram.sv =====
// ----------------------------------------------------------------------------
// dnle_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 126,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/dnle_front.sv =====
// ----------------------------------------------------------------------------
// dnle_front
// Input side: classify each word, buffer label characters, issue flushes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnle_front #(
  parameter int unsigned MAX_LABEL = 63,
  localparam int unsigned DEPTH = 2 * MAX_LABEL,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  dnle_pkg::in_word_t     in_word_i,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [7:0]             wr_data_o,
  output logic                   push_o,
  output dnle_pkg::flush_cmd_t   cmd_o,
  input  logic                   q_full_i,
  input  dnle_pkg::bank_rel_t    rel_i
);

  logic [dnle_pkg::IdxW-1:0] count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic                      bank_q, bank_d;
  logic [1:0]                busy_q, busy_d;
  logic                      accept;
  logic                      is_flush;
  logic                      has_room;

  // Hold input while the fill bank is still being read out or the queue is full.
  assign in_stall_o = busy_q[bank_q] | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_flush   = in_word_i.end_of_name | (in_word_i.char_in == dnle_pkg::DotChar);
  assign has_room   = count_q < dnle_pkg::IdxW'(MAX_LABEL);

  assign wr_en_o   = accept & ~is_flush & has_room;
  assign wr_addr_o = bank_q ? (AW'(MAX_LABEL) + AW'(count_q)) : AW'(count_q);
  assign wr_data_o = in_word_i.char_in;

  assign push_o      = accept & is_flush;
  assign cmd_o.bank  = bank_q;
  assign cmd_o.count = count_q;
  assign cmd_o.ovf   = ovf_q;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (is_flush) begin
        count_d        = '0;
        ovf_d          = 1'b0;
        bank_d         = ~bank_q;
        busy_d[bank_q] = 1'b1;
      end else if (has_room) begin
        count_d = count_q + dnle_pkg::IdxW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

// ===== src/dnle_queue.sv =====
// ----------------------------------------------------------------------------
// dnle_queue
// Two-entry queue of flush commands between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnle_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dnle_pkg::flush_cmd_t cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output dnle_pkg::flush_cmd_t cmd_o
);

  dnle_pkg::flush_cmd_t entry_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           fill_q;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== src/dnle_back.sv =====
// ----------------------------------------------------------------------------
// dnle_back
// Output side: replay one flushed label as a length byte and its characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnle_back #(
  parameter int unsigned MAX_LABEL = 63,
  localparam int unsigned DEPTH = 2 * MAX_LABEL,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  dnle_pkg::flush_cmd_t cmd_i,
  output logic                 pop_o,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  input  logic [7:0]           rd_data_i,
  output dnle_pkg::bank_rel_t  rel_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dnle_pkg::out_word_t  out_word_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0]                state_q, state_d;
  logic                      bank_q, bank_d;
  logic [dnle_pkg::IdxW-1:0] count_q, count_d;
  logic [dnle_pkg::IdxW-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  dnle_pkg::out_word_t       out_word_q, out_word_d;
  logic                      slot_free;
  logic                      last_char;

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign last_char = (idx_q + dnle_pkg::IdxW'(1)) == count_q;
  assign rd_en_o   = state_q == StRead;
  assign rd_addr_o = bank_q ? (AW'(MAX_LABEL) + AW'(idx_q)) : AW'(idx_q);

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q & out_stall_i;
    pop_o       = 1'b0;
    rel_o.valid = 1'b0;
    rel_o.bank  = bank_q;
    case (state_q)
      StIdle: begin
        if (!q_empty_i && slot_free) begin
          pop_o                     = 1'b1;
          out_valid_d               = 1'b1;
          out_word_d.out_byte       = 8'(cmd_i.count);
          out_word_d.is_length      = 1'b1;
          out_word_d.label_overflow = cmd_i.ovf;
          out_word_d.last_of_run    = cmd_i.count == '0;
          bank_d                    = cmd_i.bank;
          count_d                   = cmd_i.count;
          idx_d                     = '0;
          if (cmd_i.count == '0) begin
            // Empty label: nothing to read, free the bank now.
            rel_o.valid = 1'b1;
            rel_o.bank  = cmd_i.bank;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StLoad;
      end
      StLoad: begin
        if (slot_free) begin
          out_valid_d               = 1'b1;
          out_word_d.out_byte       = rd_data_i;
          out_word_d.is_length      = 1'b0;
          out_word_d.label_overflow = 1'b0;
          out_word_d.last_of_run    = last_char;
          if (last_char) begin
            rel_o.valid = 1'b1;
            state_d     = StIdle;
          end else begin
            idx_d   = idx_q + dnle_pkg::IdxW'(1);
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    bank_q     <= bank_d;
    count_q    <= count_d;
    idx_q      <= idx_d;
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== src/dns_name_label_encoder.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted domain name in, DNS wire labels (length byte plus characters) out.
// ----------------------------------------------------------------------------
// Feed the name one character per word; a '.' or an end word (end_of_name
// set, character ignored) flushes the buffered label as one length byte
// followed by its characters, with last_of_run on the final byte of that
// flush. Characters beyond MAX_LABEL are dropped and the length byte then
// carries label_overflow. The front accepts a character word or a flush word
// whenever in_stall_o is low. Replay of a label sends the length byte first,
// then for each character one label RAM read followed by one output load.
// The two sides overlap, so the back part's read-then-load sequence sets the
// sustained rate. The label RAM holds two banks: the next label fills one
// bank while the back part reads the other, and input stalls only when both
// banks are occupied. No clearing pass runs after reset; the block is ready
// as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_name_label_encoder #(
  parameter int unsigned MAX_LABEL = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dnle_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dnle_pkg::out_word_t out_word_o
);

  localparam int unsigned DEPTH = 2 * MAX_LABEL;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           rd_data;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  dnle_pkg::flush_cmd_t cmd_in;
  dnle_pkg::flush_cmd_t cmd_out;
  dnle_pkg::bank_rel_t  rel;

  // Front: classify words, fill the current bank, push flush commands.
  dnle_front #(
    .MAX_LABEL (MAX_LABEL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .q_full_i   (q_full),
    .rel_i      (rel)
  );

  // Short command queue: lets the front keep filling while the back drains.
  dnle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (cmd_out)
  );

  // Label store: two banks of MAX_LABEL characters.
  dnle_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_label_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Back: replay each flushed label into the output register.
  dnle_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .rel_o       (rel),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
